[hdl/scf_pkg.sv]
// ----------------------------------------------------------------------------
// scf_pkg
// Types and constants shared by the sync/length/CRC-8 frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package scf_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [INDEX_W-1:0]   t_index;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // result status codes
    localparam t_status ST_PAYLOAD = 2'd0;
    localparam t_status ST_EMPTY   = 2'd1;
    localparam t_status ST_CRC_ERR = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx CFG_SYNC_A   = 2'd0;
    localparam t_cfg_idx CFG_SYNC_B   = 2'd1;
    localparam t_cfg_idx CFG_CRC_POLY = 2'd2;

    // configuration reset values
    localparam t_byte RST_SYNC_A   = 8'd200;
    localparam t_byte RST_SYNC_B   = 8'd238;
    localparam t_byte RST_CRC_POLY = 8'd213;

    localparam t_byte CRC_TOP = 8'h80;
    localparam t_byte MIN_LEN = 8'd2;

    // request to and response from the digit-serial CRC unit
    typedef struct packed {
        logic  start;
        t_byte crc;
        t_byte data;
    } t_crc_req;

    typedef struct packed {
        logic  done;
        t_byte crc;
    } t_crc_rsp;

endpackage

`default_nettype wire

[hdl/scf_if.sv]
// ----------------------------------------------------------------------------
// scf_if
// Valid/ready channels: received bytes in, frame results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface scf_in_if import scf_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scf_out_if import scf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_byte   frame_type;
    t_byte   data_byte;
    t_index  byte_index;
    logic    last;

    modport source (output valid, output status, output frame_type, output data_byte,
                    output byte_index, output last, input ready);
    modport sink   (input valid, input status, input frame_type, input data_byte,
                    input byte_index, input last, output ready);
endinterface

`default_nettype wire

[hdl/scf_ram.sv]
// ----------------------------------------------------------------------------
// scf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/scf_crc2.sv]
// ----------------------------------------------------------------------------
// scf_crc2
// Digit-serial CRC-8, MSB first, two bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_crc2 import scf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_byte    i_poly,
    input  wire t_crc_req i_req,
    output      t_crc_rsp o_rsp
);

    logic       r_busy;
    logic       r_done;
    logic [1:0] r_cnt;
    t_byte      r_c;

    function automatic t_byte crc_bit(input t_byte c, input t_byte poly);
        t_byte sh;
        sh = {c[BYTE_W-2:0], 1'b0};
        return ((c & CRC_TOP) != '0) ? (sh ^ poly) : sh;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd3;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 2'd1;
                if (r_cnt == 2'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // data path: load the byte into the remainder, then two shift steps a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_c <= i_req.crc ^ i_req.data;
        end else if (r_busy) begin
            r_c <= crc_bit(crc_bit(r_c, i_poly), i_poly);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.crc  = r_c;

endmodule

`default_nettype wire

[hdl/sync_length_crc8_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// sync_length_crc8_frame_receiver_top
// Hunts for a sync byte, stores length, type, payload and CRC bytes, checks
// the CRC-8 and delivers the payload as a run of result words.
// ----------------------------------------------------------------------------
// One received byte is one input word. A byte while hunting, and the length
// byte, leave the block ready. Every later byte goes to the two-bit-per-cycle
// CRC unit; input waits until it reports done. At the frame's final byte the
// block emits one result (empty frame or CRC error) or drains the payload from
// the frame RAM via S_RD, S_LOAD and S_OUT per result word, S_OUT holding
// while the output stalls; input also waits during the drain. FRAME_BYTES sets
// the frame RAM depth; a frame whose length byte calls for more than
// FRAME_BYTES bytes in total is dropped, as is one whose length is below two.
// Registers (index 0: sync byte A, 1: sync byte B, 2: CRC polynomial) must be
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_crc8_frame_receiver_top import scf_pkg::*; #(
    parameter int FRAME_BYTES = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire t_cfg_idx i_cfg_idx,
    input  wire t_byte    i_cfg_data,
    scf_in_if.sink        i_rx_ch,
    scf_out_if.source     o_res_ch
);

    localparam int WP_W = $clog2(FRAME_BYTES + 1);
    localparam int AW   = $clog2(FRAME_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_RD,
        S_LOAD,
        S_OUT
    } t_state;

    t_state          r_state, n_state;
    t_byte           r_sync_a, r_sync_b, r_poly;
    logic            r_in_frame, n_in_frame;
    logic [WP_W-1:0] r_wp, n_wp;
    t_byte           r_len, n_len;
    t_byte           r_type, n_type;
    t_byte           r_crc, n_crc;
    logic [AW-1:0]   r_rd_pos, n_rd_pos;
    logic [WP_W-1:0] r_left, n_left;
    t_status         r_status, n_status;
    t_byte           r_data, n_data;
    t_index          r_idx, n_idx;
    logic            r_last, n_last;

    logic            rx_fire;
    logic            res_fire;
    t_byte           rx_b;
    t_byte           ram_rdata;
    t_crc_req        crc_req;
    t_crc_rsp        crc_rsp;
    logic [8:0]      frame_end;
    logic [WP_W-1:0] pay_cnt;

    assign rx_b     = i_rx_ch.rx_byte;
    assign rx_fire  = i_rx_ch.valid && i_rx_ch.ready;
    assign res_fire = o_res_ch.valid && o_res_ch.ready;

    assign frame_end = {1'b0, r_len} + {1'b0, MIN_LEN};
    assign pay_cnt   = WP_W'(r_len - MIN_LEN);

    assign crc_req.start = rx_fire && r_in_frame && (r_wp != WP_W'(1));
    assign crc_req.crc   = r_crc;
    assign crc_req.data  = rx_b;

    scf_crc2 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poly  (r_poly),
        .i_req   (crc_req),
        .o_rsp   (crc_rsp)
    );

    scf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (rx_fire && r_in_frame),
        .i_waddr (r_wp[AW-1:0]),
        .i_wdata (rx_b),
        .i_raddr (r_rd_pos),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_in_frame = r_in_frame;
        n_wp       = r_wp;
        n_len      = r_len;
        n_type     = r_type;
        n_crc      = r_crc;
        n_rd_pos   = r_rd_pos;
        n_left     = r_left;
        n_status   = r_status;
        n_data     = r_data;
        n_idx      = r_idx;
        n_last     = r_last;
        case (r_state)
            S_IDLE: begin
                if (rx_fire) begin
                    if (!r_in_frame) begin
                        if (rx_b == r_sync_a || rx_b == r_sync_b) begin
                            n_in_frame = 1'b1;
                            n_wp       = WP_W'(1);
                            n_crc      = '0;
                        end
                    end else if (r_wp == WP_W'(1)) begin
                        n_len = rx_b;
                        if (rx_b < MIN_LEN) begin
                            n_in_frame = 1'b0;
                            n_wp       = '0;
                        end else begin
                            n_wp = r_wp + WP_W'(1);
                        end
                    end else begin
                        if (r_wp == WP_W'(2)) begin
                            n_type = rx_b;
                        end
                        n_wp    = r_wp + WP_W'(1);
                        n_state = S_CRC;
                    end
                end
            end
            S_CRC: begin
                if (crc_rsp.done) begin
                    n_crc   = crc_rsp.crc;
                    n_state = S_IDLE;
                    if (9'(r_wp) == frame_end) begin
                        n_in_frame = 1'b0;
                        n_wp       = '0;
                        n_data     = '0;
                        n_idx      = '0;
                        n_last     = 1'b1;
                        if (crc_rsp.crc != '0) begin
                            n_status = ST_CRC_ERR;
                            n_state  = S_OUT;
                        end else if (r_len == MIN_LEN) begin
                            n_status = ST_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            // payload starts after sync, length and type
                            n_status = ST_PAYLOAD;
                            n_rd_pos = AW'(3);
                            n_left   = pay_cnt - WP_W'(1);
                            n_state  = S_RD;
                        end
                    end else if (r_wp >= WP_W'(FRAME_BYTES)) begin
                        n_in_frame = 1'b0;
                        n_wp       = '0;
                    end
                end
            end
            S_RD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_data  = ram_rdata;
                n_last  = (r_left == '0);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (res_fire) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx    = r_idx + INDEX_W'(1);
                        n_rd_pos = r_rd_pos + AW'(1);
                        n_left   = r_left - WP_W'(1);
                        n_state  = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_frame <= 1'b0;
            r_wp       <= '0;
            r_crc      <= '0;
            r_sync_a   <= RST_SYNC_A;
            r_sync_b   <= RST_SYNC_B;
            r_poly     <= RST_CRC_POLY;
        end else begin
            r_state    <= n_state;
            r_in_frame <= n_in_frame;
            r_wp       <= n_wp;
            r_crc      <= n_crc;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_A:   r_sync_a <= i_cfg_data;
                    CFG_SYNC_B:   r_sync_b <= i_cfg_data;
                    CFG_CRC_POLY: r_poly   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_type   <= n_type;
        r_rd_pos <= n_rd_pos;
        r_left   <= n_left;
        r_status <= n_status;
        r_data   <= n_data;
        r_idx    <= n_idx;
        r_last   <= n_last;
    end

    assign i_rx_ch.ready       = (r_state == S_IDLE);
    assign o_res_ch.valid      = (r_state == S_OUT);
    assign o_res_ch.status     = r_status;
    assign o_res_ch.frame_type = r_type;
    assign o_res_ch.data_byte  = r_data;
    assign o_res_ch.byte_index = r_idx;
    assign o_res_ch.last       = r_last;

    a_no_input_while_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_ch.valid |-> !i_rx_ch.ready)
        else $error("input ready while a result is pending");

    a_single_result_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && o_res_ch.status != ST_PAYLOAD) |->
        (o_res_ch.last && o_res_ch.data_byte == '0 && o_res_ch.byte_index == '0))
        else $error("empty or error result is malformed");

    a_wp_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= WP_W'(FRAME_BYTES))
        else $error("write position beyond frame store");

    a_hunt_wp_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_wp == '0))
        else $error("write position not cleared while hunting");

    a_crc_done_in_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crc_rsp.done |-> (r_state == S_CRC))
        else $error("CRC unit finished outside its wait state");

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync/length/CRC-8 frame receiver. Received bytes
// are driven as words over the input channel. Each accepted byte goes through
// a frame predictor that keeps its own copy of the registers and the frame
// store, and queues the result words that the byte should cause. Result words
// are compared field by field in order. Both channels idle and stall at random.
// Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb import scf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES    = 64;
    localparam int HOLD_CYCLES    = 800;
    localparam int IDLE_PAUSE     = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_status status;
        t_byte   frame_type;
        t_byte   data_byte;
        t_index  byte_index;
        logic    last;
    } t_frame_word;

    class frame_scoreboard;
        t_byte         sync_a;
        t_byte         sync_b;
        t_byte         poly;
        t_byte         store [FRAME_BYTES];
        int            wr_pos;
        bit            collecting;
        t_byte         crc;
        t_frame_word   pending[$];
        int            errors;

        function new();
            sync_a     = RST_SYNC_A;
            sync_b     = RST_SYNC_B;
            poly       = RST_CRC_POLY;
            wr_pos     = 0;
            collecting = 1'b0;
            crc        = '0;
            errors     = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, t_byte v);
            case (idx)
                CFG_SYNC_A:   sync_a = v;
                CFG_SYNC_B:   sync_b = v;
                CFG_CRC_POLY: poly   = v;
                default: ;
            endcase
        endfunction

        // MSB-first CRC-8 over one byte with the current polynomial
        function t_byte crc_step(t_byte c, t_byte b);
            t_byte r;
            r = c ^ b;
            for (int k = 0; k < 8; k++) begin
                if ((r & CRC_TOP) != 0) r = {r[6:0], 1'b0} ^ poly;
                else r = {r[6:0], 1'b0};
            end
            return r;
        endfunction

        function void push(t_status st, t_byte ft, t_byte d, int idx, bit lst);
            t_frame_word w;
            w.status     = st;
            w.frame_type = ft;
            w.data_byte  = d;
            w.byte_index = t_index'(idx);
            w.last       = lst;
            pending.push_back(w);
        endfunction

        // Returns 1 when the byte was part of a frame (not skipped while hunting).
        function bit note_byte(t_byte b);
            int    len;
            t_byte ftype;
            if (!collecting) begin
                if (b == sync_a || b == sync_b) begin
                    store[0]   = b;
                    wr_pos     = 1;
                    collecting = 1'b1;
                    crc        = '0;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (wr_pos >= FRAME_BYTES) begin
                collecting = 1'b0;
                return 1'b1;
            end
            store[wr_pos] = b;
            wr_pos++;
            if (wr_pos == 2) begin
                if (b < MIN_LEN) collecting = 1'b0;
                return 1'b1;
            end
            crc = crc_step(crc, b);
            len = int'(store[1]);
            if (wr_pos == len + 2) begin
                ftype      = store[2];
                collecting = 1'b0;
                if (crc != 0) push(ST_CRC_ERR, ftype, '0, 0, 1'b1);
                else if (len == int'(MIN_LEN)) push(ST_EMPTY, ftype, '0, 0, 1'b1);
                else begin
                    for (int i = 0; i < len - 2; i++)
                        push(ST_PAYLOAD, ftype, store[3 + i], i, i == len - 3);
                end
                return 1'b1;
            end
            // store full before the frame completed: drop it
            if (wr_pos >= FRAME_BYTES) collecting = 1'b0;
            return 1'b1;
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
        endfunction

        function void check_result(t_frame_word got);
            t_frame_word want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected: expected nothing, got %p",
                         $time, got);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status) flag("status", want.status, got.status);
            if (got.frame_type != want.frame_type)
                flag("frame_type", want.frame_type, got.frame_type);
            if (got.data_byte != want.data_byte) flag("data_byte", want.data_byte, got.data_byte);
            if (got.byte_index != want.byte_index)
                flag("byte_index", want.byte_index, got.byte_index);
            if (got.last != want.last) flag("last", want.last, got.last);
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_byte    i_cfg_data;

    scf_in_if  rx_ch();
    scf_out_if res_ch();

    frame_scoreboard sb;
    bit  burst;
    bit  hold_go;
    bit  hold_done;
    int  items_sent;
    int  idle_cycles = 0;

    sync_length_crc8_frame_receiver_top #(
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_ch    (rx_ch),
        .o_res_ch   (res_ch)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Result side: random stalls in stretches, plus one long hold-off on request.
    initial begin : receiver
        int stall;
        int mode_left;
        int r;
        bit steady;
        res_ch.ready = 1'b0;
        stall        = 0;
        mode_left    = 0;
        steady       = 1'b0;
        hold_done    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    steady    = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                if (stall > 0) stall--;
                else if (!steady) begin
                    r = $urandom_range(0, 99);
                    if (r < 20) stall = $urandom_range(1, 3);
                    else if (r < 23) stall = $urandom_range(10, 40);
                end
                res_ch.ready <= (stall == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_word got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.status     = res_ch.status;
            got.frame_type = res_ch.frame_type;
            got.data_byte  = res_ch.data_byte;
            got.byte_index = res_ch.byte_index;
            got.last       = res_ch.last;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no word moved in %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, sb.pending.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one byte, with a random gap first unless bursting; return once taken.
    task automatic send_byte(input t_byte b);
        int gap;
        int r;
        gap = 0;
        if (!burst) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(8, 30);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        if (sb.note_byte(b)) items_sent++;
    endtask

    task automatic send_frame(input t_byte sync, input t_byte ftype, input t_byte body[$],
                              input bit bad_crc);
        t_byte c;
        c = sb.crc_step(8'h00, ftype);
        foreach (body[i]) c = sb.crc_step(c, body[i]);
        if (bad_crc) c ^= t_byte'($urandom_range(1, 255));
        send_byte(sync);
        send_byte(t_byte'(body.size() + 2));
        send_byte(ftype);
        foreach (body[i]) send_byte(body[i]);
        send_byte(c);
    endtask

    // Length too large for the store: enough bytes to fill it, then it drops.
    task automatic send_overrun(input t_byte sync, input t_byte len);
        send_byte(sync);
        send_byte(len);
        repeat (FRAME_BYTES - 2) send_byte(t_byte'($urandom));
    endtask

    function automatic t_byte pick_sync();
        return ($urandom_range(0, 1) == 0) ? sb.sync_a : sb.sync_b;
    endfunction

    task automatic random_traffic(input int target);
        int    start;
        int    kind;
        int    n;
        t_byte body[$];
        start = items_sent;
        while (items_sent - start < target) begin
            kind  = $urandom_range(0, 99);
            burst = ($urandom_range(0, 3) == 0);
            body  = {};
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, FRAME_BYTES - 4)
                                            : $urandom_range(0, 8);
            repeat (n) body.push_back(t_byte'($urandom));
            if (kind < 70) send_frame(pick_sync(), t_byte'($urandom), body, 1'b0);
            else if (kind < 80) send_frame(pick_sync(), t_byte'($urandom), body, 1'b1);
            else if (kind < 86) repeat ($urandom_range(1, 4)) send_byte(t_byte'($urandom));
            else if (kind < 92) begin
                send_byte(pick_sync());
                send_byte(t_byte'($urandom_range(0, 1)));
            end else if (kind < 95) send_overrun(pick_sync(), t_byte'($urandom_range(63, 255)));
            else begin
                // cut the frame short; the next frame's bytes land inside it
                send_byte(pick_sync());
                send_byte(t_byte'($urandom_range(3, 20)));
                repeat ($urandom_range(0, 2)) send_byte(t_byte'($urandom));
            end
        end
        burst = 1'b0;
        while (sb.collecting) send_byte(t_byte'($urandom));
    endtask

    // Wait for the block to go idle, then rewrite the registers.
    task automatic configure(input t_byte a, input t_byte b, input t_byte poly,
                             input bit poke_unused);
        rx_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
        write_reg(CFG_SYNC_A, a);
        write_reg(CFG_SYNC_B, b);
        write_reg(CFG_CRC_POLY, poly);
        if (poke_unused) write_reg(CFG_UNUSED, t_byte'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_byte v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    initial begin
        t_byte body[$];
        sb            = new();
        burst         = 1'b0;
        hold_go       = 1'b0;
        items_sent    = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SYNC_A;
        i_cfg_data    = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: hunting noise, empty payload, short lengths, sync as data, bad CRC
        send_byte(8'h00);
        send_byte(8'hFF);
        body = {};
        send_frame(sb.sync_a, 8'hFF, body, 1'b0);
        send_byte(sb.sync_b);
        send_byte(8'd0);
        send_byte(sb.sync_a);
        send_byte(8'd1);
        body = {sb.sync_a, 8'hFF, 8'h00};
        send_frame(sb.sync_b, 8'h00, body, 1'b0);
        body = {8'h3C};
        send_frame(sb.sync_a, 8'h5A, body, 1'b1);
        random_traffic(5);

        configure(8'h00, 8'hFF, 8'hFF, 1'b0);
        // hold the result side while a full-size frame drains and more bytes queue up
        burst   = 1'b1;
        hold_go = 1'b1;
        body    = {};
        repeat (FRAME_BYTES - 4) body.push_back(t_byte'($urandom));
        send_frame(pick_sync(), t_byte'($urandom), body, 1'b0);
        body = {8'hA5, 8'h5A};
        send_frame(pick_sync(), t_byte'($urandom), body, 1'b0);
        burst = 1'b0;
        send_overrun(pick_sync(), 8'd63);
        random_traffic(5);

        configure(8'h7E, 8'h7E, 8'h00, 1'b1);
        random_traffic(5);

        configure(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom), 1'b1);
        random_traffic(10);

        rx_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

[filelist.f]
hdl/scf_pkg.sv
hdl/scf_if.sv
hdl/scf_ram.sv
hdl/scf_crc2.sv
hdl/sync_length_crc8_frame_receiver_top.sv
verif/tb.sv
